### rtl/rclp_pkg.sv
// Shared types, codes and a helper function of the RTC command line parser.
package rclp_pkg;

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_DASH  = 8'h2D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // Keywords, first character at index 0.
  localparam logic [3:0][7:0] WORD_DATE = {8'h65, 8'h74, 8'h61, 8'h64};
  localparam logic [3:0][7:0] WORD_TIME = {8'h65, 8'h6D, 8'h69, 8'h74};
  localparam logic [3:0][7:0] WORD_SET  = {8'h00, 8'h74, 8'h65, 8'h73};

  localparam logic [15:0] YEAR_CENTURY = 16'd2000;
  localparam logic [16:0] RECIP_100    = 17'd83887;  // ceil(2^23 / 100)
  localparam int          RECIP_SHIFT  = 23;

  typedef enum logic [3:0] {
    STAT_DATE_Q    = 4'd0,
    STAT_TIME_Q    = 4'd1,
    STAT_SET_DATE  = 4'd2,
    STAT_SET_TIME  = 4'd3,
    STAT_OVERFLOW  = 4'd4,
    STAT_BAD_CMD   = 4'd5,
    STAT_BAD_SUB   = 4'd6,
    STAT_BAD_DAY   = 4'd7,
    STAT_BAD_MONTH = 4'd8,
    STAT_BAD_YEAR  = 4'd9,
    STAT_BAD_HOURS = 4'd10,
    STAT_BAD_MIN   = 4'd11,
    STAT_BAD_SEC   = 4'd12
  } status_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_STORE,
    OP_START,
    OP_HEAD_STEP,
    OP_SUB_STEP,
    OP_SEP_OK,
    OP_WS_SKIP,
    OP_SIGN,
    OP_DIGIT,
    OP_NUM_END,
    OP_FIN1,
    OP_FIN2,
    OP_FIN3,
    OP_RESULT
  } dp_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HEAD_RD,
    ST_HEAD,
    ST_SUB_RD,
    ST_SUB,
    ST_SEP_RD,
    ST_SEP,
    ST_WS_RD,
    ST_WS,
    ST_DIG_RD,
    ST_DIG,
    ST_FIN1,
    ST_FIN2,
    ST_FIN3
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e  op;
    status_e code;
  } dp_cmd_t;

  typedef struct packed {
    logic       full;
    logic       rx_cr;
    logic       head_date;
    logic       head_time;
    logic       head_set;
    logic       head_last;
    logic       sub_date;
    logic       sub_time;
    logic       sub_last;
    logic       set_short;
    logic       sep_ok;
    logic       is_ws;
    logic       is_sign;
    logic       is_digit;
    logic       num_last;
    logic       kind_date;
    logic [1:0] num_idx;
  } dp_stat_t;

  // Two BCD digits of an 8-bit value; tens digit wraps above 159.
  function automatic logic [7:0] bcd8(input logic [7:0] v);
    logic [15:0] prod;
    logic [7:0]  q;
    logic [7:0]  r;
    prod = 16'(v) * 16'd205;
    q    = {3'b000, prod[15:11]};
    r    = v - 8'(q * 8'd10);
    return {q[3:0], r[3:0]};
  endfunction

endpackage

### rtl/rclp_ctrl.sv
// Controller state machine of the RTC command line parser.
module rclp_ctrl
  import rclp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        skip_q, skip_d;
  logic        out_valid_q, out_valid_d;
  logic        in_acc;
  status_e     num_err;

  assign in_acc      = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;
  assign num_err     = stat_i.kind_date
                       ? status_e'(4'(STAT_BAD_DAY) + {2'b00, stat_i.num_idx})
                       : status_e'(4'(STAT_BAD_HOURS) + {2'b00, stat_i.num_idx});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      skip_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      skip_q      <= skip_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && !skip_q && !stat_i.full && stat_i.rx_cr) state_d = ST_HEAD_RD;
      end
      ST_HEAD_RD: state_d = ST_HEAD;
      ST_HEAD: begin
        if (!stat_i.head_last) state_d = ST_HEAD_RD;
        else if (stat_i.head_set && !stat_i.head_date && !stat_i.head_time &&
                 !stat_i.set_short) state_d = ST_SUB_RD;
        else state_d = ST_IDLE;
      end
      ST_SUB_RD: state_d = ST_SUB;
      ST_SUB: begin
        if (!stat_i.sub_last) state_d = ST_SUB_RD;
        else if (stat_i.sub_date || stat_i.sub_time) state_d = ST_SEP_RD;
        else state_d = ST_IDLE;
      end
      ST_SEP_RD: state_d = ST_SEP;
      ST_SEP: state_d = stat_i.sep_ok ? ST_WS_RD : ST_IDLE;
      ST_WS_RD: state_d = ST_WS;
      ST_WS: begin
        if (stat_i.is_ws) state_d = ST_WS_RD;
        else if (stat_i.is_sign) state_d = ST_DIG_RD;
        else state_d = ST_DIG;
      end
      ST_DIG_RD: state_d = ST_DIG;
      ST_DIG: begin
        if (stat_i.is_digit) state_d = ST_DIG_RD;
        else if (stat_i.num_last) state_d = ST_FIN1;
        else state_d = ST_SEP_RD;
      end
      ST_FIN1: state_d = ST_FIN2;
      ST_FIN2: state_d = ST_FIN3;
      ST_FIN3: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '{op: OP_NONE, code: STAT_DATE_Q};
    skip_d      = skip_q;
    out_valid_d = out_valid_q & out_stall_i;
    in_stall_o  = (state_q != ST_IDLE) ||
                  (out_valid_q && !skip_q && (stat_i.full || stat_i.rx_cr));
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (skip_q) begin
            skip_d = 1'b0;
          end else if (stat_i.full) begin
            cmd_o       = '{op: OP_RESULT, code: STAT_OVERFLOW};
            skip_d      = stat_i.rx_cr;
            out_valid_d = 1'b1;
          end else if (stat_i.rx_cr) begin
            cmd_o.op = OP_START;
            skip_d   = 1'b1;
          end else begin
            cmd_o.op = OP_STORE;
          end
        end
      end
      ST_HEAD: begin
        cmd_o.op = OP_HEAD_STEP;
        if (stat_i.head_last) begin
          if (stat_i.head_date) begin
            cmd_o       = '{op: OP_RESULT, code: STAT_DATE_Q};
            out_valid_d = 1'b1;
          end else if (stat_i.head_time) begin
            cmd_o       = '{op: OP_RESULT, code: STAT_TIME_Q};
            out_valid_d = 1'b1;
          end else if (!stat_i.head_set) begin
            cmd_o       = '{op: OP_RESULT, code: STAT_BAD_CMD};
            out_valid_d = 1'b1;
          end else if (stat_i.set_short) begin
            cmd_o       = '{op: OP_RESULT, code: STAT_BAD_SUB};
            out_valid_d = 1'b1;
          end
        end
      end
      ST_SUB: begin
        cmd_o.op = OP_SUB_STEP;
        if (stat_i.sub_last && !stat_i.sub_date && !stat_i.sub_time) begin
          cmd_o       = '{op: OP_RESULT, code: STAT_BAD_SUB};
          out_valid_d = 1'b1;
        end
      end
      ST_SEP: begin
        if (stat_i.sep_ok) begin
          cmd_o.op = OP_SEP_OK;
        end else begin
          cmd_o       = '{op: OP_RESULT, code: num_err};
          out_valid_d = 1'b1;
        end
      end
      ST_WS: begin
        if (stat_i.is_ws) cmd_o.op = OP_WS_SKIP;
        else if (stat_i.is_sign) cmd_o.op = OP_SIGN;
      end
      ST_DIG: cmd_o.op = stat_i.is_digit ? OP_DIGIT : OP_NUM_END;
      ST_FIN1: cmd_o.op = OP_FIN1;
      ST_FIN2: cmd_o.op = OP_FIN2;
      ST_FIN3: begin
        cmd_o.op    = OP_FIN3;
        out_valid_d = 1'b1;
      end
      default: cmd_o.op = OP_NONE;
    endcase
  end

endmodule

### rtl/rclp_dp.sv
// Datapath of the RTC command line parser: line store, scanner and result registers.
module rclp_dp
  import rclp_pkg::*;
#(
  parameter int LINE_LIMIT = 20
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] rx_byte_i,
  input  dp_cmd_t    cmd_i,
  output dp_stat_t   stat_o,
  output logic [3:0] status_o,
  output logic [7:0] byte_a_o,
  output logic [7:0] byte_b_o,
  output logic [7:0] byte_c_o
);

  localparam int CW = $clog2(LINE_LIMIT + 1);
  localparam int AW = $clog2(LINE_LIMIT);

  logic [7:0]    mem [LINE_LIMIT];
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] pos_q, pos_d;
  logic [CW-1:0] p_q, p_d;
  logic [7:0]    rd_q;
  logic          inr_q;
  logic          hd_q, hd_d, ht_q, ht_d, hs_q, hs_d;
  logic          sd_q, sd_d, st_q, st_d;
  logic          kind_q, kind_d;
  logic [1:0]    k_q, k_d;
  logic [31:0]   mag_q, mag_d;
  logic          neg_q, neg_d, any_q, any_d;
  logic [7:0]    x_q, x_d, y_q, y_d;
  logic [15:0]   z_q, z_d;
  logic [9:0]    yq_q, yq_d;
  logic [6:0]    yr_q, yr_d;
  logic [3:0]    status_q, status_d;
  logic [7:0]    a_q, a_d, b_q, b_d, c_q, c_d;

  logic [7:0]  ch;
  logic [7:0]  sep;
  logic [35:0] mag_ext;
  logic [35:0] mag_next;
  logic [31:0] neg_mag;
  logic [15:0] num_val;
  logic [32:0] yprod;
  logic [16:0] yrem;
  logic [7:0]  dig;

  assign ch  = inr_q ? rd_q : 8'h00;
  assign sep = (k_q == 2'd0) ? CHAR_SPACE : (kind_q ? CHAR_DASH : CHAR_COLON);
  assign dig = ch - CHAR_ZERO;

  always_comb begin
    stat_o.full      = count_q >= CW'(LINE_LIMIT);
    stat_o.rx_cr     = rx_byte_i == CHAR_CR;
    stat_o.head_date = hd_q && ch == WORD_DATE[pos_q[1:0]];
    stat_o.head_time = ht_q && ch == WORD_TIME[pos_q[1:0]];
    stat_o.head_set  = hs_q && (pos_q == CW'(3) || ch == WORD_SET[pos_q[1:0]]);
    stat_o.head_last = pos_q == CW'(3);
    stat_o.sub_date  = sd_q && ch == WORD_DATE[pos_q[1:0]];
    stat_o.sub_time  = st_q && ch == WORD_TIME[pos_q[1:0]];
    stat_o.sub_last  = pos_q == CW'(7);
    stat_o.set_short = count_q <= CW'(4);
    stat_o.sep_ok    = ({1'b0, count_q} > ({1'b0, pos_q} + (CW + 1)'(1))) && ch == sep;
    stat_o.is_ws     = ch == CHAR_SPACE || (ch >= CHAR_TAB && ch <= CHAR_CR);
    stat_o.is_sign   = ch == CHAR_PLUS || ch == CHAR_DASH;
    stat_o.is_digit  = ch >= CHAR_ZERO && ch <= CHAR_NINE;
    stat_o.num_last  = k_q == 2'd2;
    stat_o.kind_date = kind_q;
    stat_o.num_idx   = k_q;
  end

  // Saturating decimal accumulate, field value and the divide-by-100 terms of the year.
  always_comb begin
    mag_ext  = {4'b0000, mag_q};
    mag_next = (mag_ext << 3) + (mag_ext << 1) + {32'd0, dig[3:0]};
    if (mag_next > 36'h080000000) mag_next = 36'h080000000;
    neg_mag = 32'd0 - mag_q;
    if (!any_q) num_val = 16'd0;
    else if (neg_q) num_val = neg_mag[15:0];
    else if (mag_q == 32'h80000000) num_val = 16'hFFFF;
    else num_val = mag_q[15:0];
    yprod = 33'(z_q) * 33'(RECIP_100);
    yrem  = 17'(z_q) - 17'(yq_q) * 17'd100;
  end

  always_comb begin
    count_d  = count_q;
    pos_d    = pos_q;
    p_d      = p_q;
    hd_d     = hd_q;
    ht_d     = ht_q;
    hs_d     = hs_q;
    sd_d     = sd_q;
    st_d     = st_q;
    kind_d   = kind_q;
    k_d      = k_q;
    mag_d    = mag_q;
    neg_d    = neg_q;
    any_d    = any_q;
    x_d      = x_q;
    y_d      = y_q;
    z_d      = z_q;
    yq_d     = yq_q;
    yr_d     = yr_q;
    status_d = status_q;
    a_d      = a_q;
    b_d      = b_q;
    c_d      = c_q;
    case (cmd_i.op)
      OP_STORE: count_d = count_q + CW'(1);
      OP_START: begin
        pos_d = '0;
        hd_d  = 1'b1;
        ht_d  = 1'b1;
        hs_d  = 1'b1;
        sd_d  = 1'b1;
        st_d  = 1'b1;
        k_d   = 2'd0;
        mag_d = '0;
        neg_d = 1'b0;
        any_d = 1'b0;
      end
      OP_HEAD_STEP: begin
        hd_d  = stat_o.head_date;
        ht_d  = stat_o.head_time;
        hs_d  = stat_o.head_set;
        pos_d = pos_q + CW'(1);
      end
      OP_SUB_STEP: begin
        sd_d   = stat_o.sub_date;
        st_d   = stat_o.sub_time;
        kind_d = stat_o.sub_date;
        pos_d  = pos_q + CW'(1);
      end
      OP_SEP_OK: begin
        pos_d = pos_q + CW'(1);
        p_d   = pos_q + CW'(1);
      end
      OP_WS_SKIP: pos_d = pos_q + CW'(1);
      OP_SIGN: begin
        neg_d = ch == CHAR_DASH;
        pos_d = pos_q + CW'(1);
      end
      OP_DIGIT: begin
        mag_d = mag_next[31:0];
        any_d = 1'b1;
        pos_d = pos_q + CW'(1);
      end
      OP_NUM_END: begin
        case (k_q)
          2'd0:    x_d = num_val[7:0];
          2'd1:    y_d = num_val[7:0];
          default: z_d = num_val;
        endcase
        if (!any_q) pos_d = p_q;
        k_d   = k_q + 2'd1;
        mag_d = '0;
        neg_d = 1'b0;
        any_d = 1'b0;
      end
      OP_FIN1: yq_d = yprod[RECIP_SHIFT +: 10];
      OP_FIN2: yr_d = (yrem[15:0] >= 16'd100) ? 7'(yrem[15:0] - 16'd100) : yrem[6:0];
      OP_FIN3: begin
        count_d = '0;
        a_d     = bcd8(x_q);
        if (kind_q) begin
          status_d = STAT_SET_DATE;
          b_d      = bcd8(y_q) | {(z_q >= YEAR_CENTURY), 7'd0};
          c_d      = bcd8({1'b0, yr_q});
        end else begin
          status_d = STAT_SET_TIME;
          b_d      = bcd8(y_q);
          c_d      = bcd8(z_q[7:0]);
        end
      end
      OP_RESULT: begin
        count_d  = '0;
        status_d = cmd_i.code;
        a_d      = 8'd0;
        b_d      = 8'd0;
        c_d      = 8'd0;
      end
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_STORE) mem[count_q[AW-1:0]] <= rx_byte_i;
    rd_q <= mem[pos_q[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      k_q     <= 2'd0;
    end else begin
      count_q <= count_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    inr_q    <= pos_q < count_q;
    pos_q    <= pos_d;
    p_q      <= p_d;
    hd_q     <= hd_d;
    ht_q     <= ht_d;
    hs_q     <= hs_d;
    sd_q     <= sd_d;
    st_q     <= st_d;
    kind_q   <= kind_d;
    mag_q    <= mag_d;
    neg_q    <= neg_d;
    any_q    <= any_d;
    x_q      <= x_d;
    y_q      <= y_d;
    z_q      <= z_d;
    yq_q     <= yq_d;
    yr_q     <= yr_d;
    status_q <= status_d;
    a_q      <= a_d;
    b_q      <= b_d;
    c_q      <= c_d;
  end

  assign status_o = status_q;
  assign byte_a_o = a_q;
  assign byte_b_o = b_q;
  assign byte_c_o = c_q;

endmodule

### rtl/rtc_command_line_parser.sv
// Top level of the RTC command line parser: controller plus datapath.
//
// Collects received characters into a line of up to LINE_LIMIT bytes and, on
// a carriage return, parses it into one result item: a date or time query, a
// set-date or set-time command with three BCD register bytes (day or hours,
// century bit plus month or minutes, year mod 100 or seconds), or a numbered
// error. The character after a carriage return is dropped. A character that
// arrives on a full line ends it with an overflow result and is dropped; if it
// is a carriage return the next character is dropped as well. Ordinary
// characters are stored as they arrive while no scan runs. A carriage return
// starts a scan of the line that reads the line store byte by byte through
// its registered read port, during which input is stalled. A query or a bad
// command is decided at the fourth byte position. A set command examines
// each byte in turn (the byte that ends a number and the bytes of a number
// without digits are examined again) and then builds the BCD bytes in the
// finishing states FIN1, FIN2 and FIN3. A finished result sits in the output
// register; ordinary characters keep flowing while it waits, but a character
// that would end a line is held until the result is taken.
module rtc_command_line_parser
  import rclp_pkg::*;
#(
  parameter int LINE_LIMIT = 20
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [3:0] status_o,
  output logic [7:0] byte_a_o,
  output logic [7:0] byte_b_o,
  output logic [7:0] byte_c_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  rclp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  rclp_dp #(
    .LINE_LIMIT (LINE_LIMIT)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rx_byte_i (rx_byte_i),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .status_o  (status_o),
    .byte_a_o  (byte_a_o),
    .byte_b_o  (byte_b_o),
    .byte_c_o  (byte_c_o)
  );

endmodule

### bench/rtc_command_line_parser_test.sv
// Self-checking testbench of the RTC command line parser: directed and random lines.
module rtc_command_line_parser_test;
  import rclp_pkg::*;

  localparam int LINE_MAX   = 20;
  localparam int CYCLE_CAP  = 800000;
  localparam int ITEM_GOAL  = 1330;

  typedef struct {
    status_e    status;
    logic [7:0] byte_a;
    logic [7:0] byte_b;
    logic [7:0] byte_c;
  } reply_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] rx_byte;
  logic       out_valid;
  logic       out_stall;
  logic [3:0] status;
  logic [7:0] byte_a;
  logic [7:0] byte_b;
  logic [7:0] byte_c;

  // Predictor copy of the line and its bookkeeping.
  logic [7:0] line_buf [LINE_MAX];
  int         line_len;
  bit         drop_next;

  reply_t     pending_replies [$];
  int         fail_cnt;
  int         cycle_cnt;
  int         sent_cnt;
  bit         idle_en;
  int         hold_cycles;

  rtc_command_line_parser #(.LINE_LIMIT(LINE_MAX)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .rx_byte_i  (rx_byte),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .status_o   (status),
    .byte_a_o   (byte_a),
    .byte_b_o   (byte_b),
    .byte_c_o   (byte_c)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------
  // Line predictor
  // ---------------------------------------------------------------------
  function automatic logic [7:0] char_at(int i);
    if (i >= 0 && i < line_len && i < LINE_MAX) return line_buf[i];
    return 8'h00;
  endfunction

  function automatic bit word_at(int pos, logic [3:0][7:0] word, int n);
    if (pos > line_len || line_len - pos < n) return 1'b0;
    for (int i = 0; i < n; i++)
      if (char_at(pos + i) != word[i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic bit blank_char(logic [7:0] c);
    return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
  endfunction

  // Read one separated decimal; false when the separator is missing or ends the line.
  function automatic bit scan_field(inout int pos, input logic [7:0] sep,
                                    output logic [31:0] val);
    int      p;
    int      q;
    longint  mag;
    bit      neg;
    bit      any;
    mag = 0;
    neg = 1'b0;
    any = 1'b0;
    val = '0;
    if (pos > line_len || line_len - pos <= 1 || char_at(pos) != sep) return 1'b0;
    p = pos + 1;
    q = p;
    while (blank_char(char_at(q))) q++;
    if (char_at(q) == CHAR_PLUS || char_at(q) == CHAR_DASH) begin
      neg = (char_at(q) == CHAR_DASH);
      q++;
    end
    while (char_at(q) >= CHAR_ZERO && char_at(q) <= CHAR_NINE) begin
      mag = mag * 10 + (char_at(q) - CHAR_ZERO);
      if (mag > 64'h8000_0000) mag = 64'h8000_0000;
      any = 1'b1;
      q++;
    end
    if (!any) begin
      pos = p;
      return 1'b1;
    end
    if (neg) val = 32'd0 - mag[31:0];
    else val = (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    pos = q;
    return 1'b1;
  endfunction

  function automatic logic [7:0] to_bcd(logic [31:0] v);
    logic [31:0] r;
    r = ((v / 10) << 4) | (v % 10);
    return r[7:0];
  endfunction

  function automatic reply_t decode_line();
    reply_t      r;
    int          pos;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    r.byte_a = '0;
    r.byte_b = '0;
    r.byte_c = '0;
    if (word_at(0, WORD_DATE, 4)) begin r.status = STAT_DATE_Q; return r; end
    if (word_at(0, WORD_TIME, 4)) begin r.status = STAT_TIME_Q; return r; end
    if (!word_at(0, WORD_SET, 3)) begin r.status = STAT_BAD_CMD; return r; end
    pos = 3;
    if (line_len - pos <= 1) begin r.status = STAT_BAD_SUB; return r; end
    pos++;
    if (word_at(pos, WORD_DATE, 4)) begin
      pos += 4;
      if (!scan_field(pos, CHAR_SPACE, x)) begin r.status = STAT_BAD_DAY; return r; end
      if (!scan_field(pos, CHAR_DASH, y)) begin r.status = STAT_BAD_MONTH; return r; end
      if (!scan_field(pos, CHAR_DASH, z)) begin r.status = STAT_BAD_YEAR; return r; end
      z = z & 32'hFFFF;
      r.status = STAT_SET_DATE;
      r.byte_a = to_bcd(x & 32'hFF);
      r.byte_b = ((z >= 2000) ? 8'h80 : 8'h00) | to_bcd(y & 32'hFF);
      r.byte_c = to_bcd(z % 100);
      return r;
    end
    if (word_at(pos, WORD_TIME, 4)) begin
      pos += 4;
      if (!scan_field(pos, CHAR_SPACE, x)) begin r.status = STAT_BAD_HOURS; return r; end
      if (!scan_field(pos, CHAR_COLON, y)) begin r.status = STAT_BAD_MIN; return r; end
      if (!scan_field(pos, CHAR_COLON, z)) begin r.status = STAT_BAD_SEC; return r; end
      r.status = STAT_SET_TIME;
      r.byte_a = to_bcd(x & 32'hFF);
      r.byte_b = to_bcd(y & 32'hFF);
      r.byte_c = to_bcd(z & 32'hFF);
      return r;
    end
    r.status = STAT_BAD_SUB;
    return r;
  endfunction

  // Advance the predictor by one accepted character.
  function automatic void take_char(logic [7:0] c);
    reply_t r;
    if (drop_next) begin
      drop_next = 1'b0;
      return;
    end
    if (line_len >= LINE_MAX) begin
      line_len  = 0;
      drop_next = (c == CHAR_CR);
      r.status  = STAT_OVERFLOW;
      r.byte_a  = '0;
      r.byte_b  = '0;
      r.byte_c  = '0;
      pending_replies.push_back(r);
      return;
    end
    if (c == CHAR_CR) begin
      pending_replies.push_back(decode_line());
      line_len  = 0;
      drop_next = 1'b1;
      return;
    end
    line_buf[line_len] = c;
    line_len++;
  endfunction

  // ---------------------------------------------------------------------
  // Sender, receiver, checker
  // ---------------------------------------------------------------------
  // Offer one item, idling first at random; hold it until it is taken.
  task automatic send_char(input logic [7:0] c);
    logic stalled;
    if (idle_en && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 30);
    end
    in_valid <= 1'b1;
    rx_byte  <= c;
    forever begin
      @(negedge clk_i);
      stalled = in_stall;
      @(posedge clk_i);
      if (!stalled) break;
    end
    take_char(c);
    sent_cnt++;
  endtask

  task automatic send_bytes(input logic [7:0] q [$]);
    foreach (q[i]) send_char(q[i]);
  endtask

  function automatic void add_text(ref logic [7:0] q [$], input string s);
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
  endfunction

  // Send text, then a carriage return and the character that gets dropped.
  task automatic send_line(input string s);
    logic [7:0] q [$];
    add_text(q, s);
    q.push_back(CHAR_CR);
    q.push_back(8'($urandom_range(255)));
    send_bytes(q);
  endtask

  // Stop offering and wait until every expected result has come.
  task automatic wait_drained();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_replies.size() != 0) @(posedge clk_i);
    while (guard < 60) begin
      @(posedge clk_i);
      guard++;
    end
  endtask

  // Receiver stall: a long hold when asked, otherwise random idling.
  initial begin
    out_stall = 1'b1;
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= idle_en && ($urandom_range(99) < 30);
      end
    end
  end

  // Compare a result taken at the coming edge with the oldest expectation.
  always @(negedge clk_i) begin
    reply_t e;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_replies.size() == 0) begin
        $error("result with nothing expected: status %0d", status);
        fail_cnt++;
      end else begin
        e = pending_replies.pop_front();
        if (status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, status);
          fail_cnt++;
        end
        if (byte_a !== e.byte_a) begin
          $error("byte_a expected %02h actual %02h", e.byte_a, byte_a);
          fail_cnt++;
        end
        if (byte_b !== e.byte_b) begin
          $error("byte_b expected %02h actual %02h", e.byte_b, byte_b);
          fail_cnt++;
        end
        if (byte_c !== e.byte_c) begin
          $error("byte_c expected %02h actual %02h", e.byte_c, byte_c);
          fail_cnt++;
        end
      end
    end
  end

  // Guard against a hang.
  initial begin
    cycle_cnt = 0;
    forever begin
      @(posedge clk_i);
      cycle_cnt++;
      if (cycle_cnt > CYCLE_CAP) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Random line builders
  // ---------------------------------------------------------------------
  function automatic void add_number(ref logic [7:0] q [$]);
    int nd;
    repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0)
      q.push_back($urandom_range(1) ? CHAR_SPACE : CHAR_TAB);
    if ($urandom_range(3) == 0) q.push_back($urandom_range(1) ? CHAR_DASH : CHAR_PLUS);
    nd = ($urandom_range(19) == 0) ? 11 : $urandom_range(0, 4);
    repeat (nd) q.push_back(8'(CHAR_ZERO + $urandom_range(9)));
  endfunction

  function automatic void add_set(ref logic [7:0] q [$]);
    bit         is_date;
    logic [7:0] sep;
    is_date = 1'($urandom_range(1));
    sep     = is_date ? CHAR_DASH : CHAR_COLON;
    add_text(q, "set");
    q.push_back($urandom_range(3) ? CHAR_SPACE : 8'($urandom_range(255)));
    add_text(q, is_date ? "date" : "time");
    q.push_back(CHAR_SPACE);
    add_number(q);
    q.push_back(sep);
    add_number(q);
    q.push_back(sep);
    add_number(q);
  endfunction

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  task automatic test_queries_and_sets();
    send_line("date");
    send_line("time and more");
    send_line("set date 31-12-1999");
    send_line("set_date 01-01-2000");
    send_line("set time 23:59:59");
    send_line("set time -1:+7:255");
    send_line("set date 99999999999-0-");
    send_line("set time\t 5:6:");
  endtask

  task automatic test_errors();
    send_line("");
    send_line("dat");
    send_line("set");
    send_line("set ");
    send_line("set year");
    send_line("set date");
    send_line("set date 1");
    send_line("set date 1-2");
    send_line("set time");
    send_line("set time 1");
    send_line("set time 1:2");
    send_line("set time 1-2-3");
  endtask

  task automatic test_zero_byte();
    logic [7:0] q [$];
    add_text(q, "set date 1");
    q.push_back(8'h00);
    add_text(q, "2-3-4");
    q.push_back(CHAR_CR);
    q.push_back(8'hFF);
    send_bytes(q);
  endtask

  // Full lines: an ordinary character and a carriage return as the spill.
  task automatic test_overflow();
    logic [7:0] q [$];
    repeat (LINE_MAX) q.push_back(8'h41);
    q.push_back(8'h42);
    repeat (LINE_MAX) q.push_back(8'h43);
    q.push_back(CHAR_CR);
    q.push_back(CHAR_CR);
    add_text(q, "time");
    q.push_back(CHAR_CR);
    q.push_back(8'h00);
    send_bytes(q);
  endtask

  // Hold the result port while lines keep coming, so the input backs up.
  task automatic test_backpressure();
    bit keep;
    keep    = idle_en;
    idle_en = 1'b0;
    hold_cycles = 400;
    repeat (6) send_line("set time 1:2:3");
    idle_en = keep;
    wait_drained();
  endtask

  task automatic test_random();
    logic [7:0] q [$];
    int         kind;
    int         start;
    start = sent_cnt;
    while (sent_cnt - start < ITEM_GOAL) begin
      // Send without idling until more than 300 items have gone, then idle at random.
      idle_en = (sent_cnt - start) > 300;
      q.delete();
      kind = $urandom_range(9);
      if (kind <= 5) begin
        add_set(q);
      end else if (kind == 6) begin
        add_set(q);
        q[$urandom_range(q.size() - 1)] = 8'($urandom_range(255));
      end else if (kind == 7) begin
        add_text(q, $urandom_range(1) ? "date" : "time");
        repeat ($urandom_range(0, 18)) q.push_back(8'($urandom_range(255)));
      end else if (kind == 8) begin
        repeat ($urandom_range(0, 24)) q.push_back(8'($urandom_range(255)));
      end else begin
        repeat ($urandom_range(LINE_MAX, LINE_MAX + 3)) q.push_back(8'($urandom_range(255)));
      end
      q.push_back(CHAR_CR);
      q.push_back(8'($urandom_range(255)));
      send_bytes(q);
    end
    idle_en = 1'b1;
  endtask

  initial begin
    in_valid    = 1'b0;
    rx_byte     = 8'h00;
    rst_ni      = 1'b0;
    fail_cnt    = 0;
    sent_cnt    = 0;
    idle_en     = 1'b1;
    hold_cycles = 0;
    line_len    = 0;
    drop_next   = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_queries_and_sets();
    test_errors();
    test_zero_byte();
    test_overflow();
    wait_drained();
    test_backpressure();
    test_random();
    wait_drained();

    if (fail_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
